>>> rtl/core/kms_pkg.sv
// kms_pkg: shared widths, defaults and types for the k-way merge selector.
// No dependencies; compile first.
package kms_pkg;

  localparam int STREAMS_DEF = 8;   // default number of merged streams
  localparam int STREAM_W    = 3;   // width of the stream index fields
  localparam int KEY_W       = 31;  // width of a key
  localparam int QDEPTH      = 4;   // entries in the front-to-back queue

  // One refill command as it travels from front to back.
  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic [KEY_W-1:0]    key;
    logic                stream_end;
  } cmd_t;

  // Push side of the queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Queue occupancy flags.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/kms_in_if.sv
// kms_in_if: refill channel (stream, key, stream_end) with valid/ready.
// Depends on kms_pkg.
interface kms_in_if;
  import kms_pkg::*;

  logic                valid;
  logic                ready;
  logic [STREAM_W-1:0] stream;
  logic [KEY_W-1:0]    key;
  logic                stream_end;

  modport source (output valid, output stream, output key, output stream_end, input ready);
  modport sink   (input valid, input stream, input key, input stream_end, output ready);
endinterface

>>> rtl/core/kms_out_if.sv
// kms_out_if: result channel (winner_stream, winner_key, all_done) with valid/ready.
// Depends on kms_pkg.
interface kms_out_if;
  import kms_pkg::*;

  logic                valid;
  logic                ready;
  logic [STREAM_W-1:0] winner_stream;
  logic [KEY_W-1:0]    winner_key;
  logic                all_done;

  modport source (output valid, output winner_stream, output winner_key, output all_done,
                  input ready);
  modport sink   (input valid, input winner_stream, input winner_key, input all_done,
                  output ready);
endinterface

>>> rtl/core/kms_front.sv
// kms_front: accepts refill beats, drops those aimed at absent streams,
// and pushes the rest into the queue. Depends on kms_pkg, kms_in_if.
module kms_front #(
  parameter int STREAMS = kms_pkg::STREAMS_DEF
) (
  input  logic             rst,
  kms_in_if.sink           refill,
  input  kms_pkg::q_stat_t q_stat,
  output kms_pkg::push_t   push
);
  import kms_pkg::*;

  logic in_range;

  assign refill.ready = !q_stat.full;
  assign in_range     = int'(refill.stream) < STREAMS;

  always_comb begin
    push.valid          = refill.valid && refill.ready && in_range && !rst;
    push.cmd.stream     = refill.stream;
    push.cmd.key        = refill.key;
    push.cmd.stream_end = refill.stream_end;
  end

endmodule

>>> rtl/core/kms_queue.sv
// kms_queue: short register FIFO of refill commands between front and back.
// Depends on kms_pkg.
module kms_queue (
  input  logic             clk,
  input  logic             rst,
  input  kms_pkg::push_t   push,
  input  logic             pop,
  output kms_pkg::head_t   head,
  output kms_pkg::q_stat_t stat
);
  import kms_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_pop;

  assign stat.full  = (count == CW'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_pop     = pop && !stat.empty;

  assign head.valid = !stat.empty;
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/kms_back.sv
// kms_back: head registers, minimum-select tree and output register.
// Applies one queued refill per cycle while the result is not stalled. Depends on kms_pkg, kms_out_if.
module kms_back #(
  parameter int STREAMS = kms_pkg::STREAMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  kms_pkg::head_t head,
  output logic           pop,
  kms_out_if.source      result
);
  import kms_pkg::*;

  localparam int SW = $clog2(STREAMS);
  localparam int P  = 1 << SW;

  logic [KEY_W-1:0]   head_key [STREAMS];
  logic [STREAMS-1:0] head_valid;
  logic [STREAMS-1:0] head_ended;
  logic               finished;

  logic [KEY_W-1:0]   key_next [STREAMS];
  logic [STREAMS-1:0] valid_next;
  logic [STREAMS-1:0] ended_next;
  logic [STREAMS-1:0] win_clear;

  logic               node_v [2*P];
  logic [KEY_W-1:0]   node_k [2*P];
  logic [SW-1:0]      node_i [2*P];

  logic               out_valid;
  logic [STREAM_W-1:0] out_stream;
  logic [KEY_W-1:0]   out_key;
  logic               out_done;

  logic               back_ready;
  logic               apply;
  logic [SW-1:0]      sel;
  logic               all_end;
  logic               heads_ready;
  logic               emit;

  assign back_ready = !out_valid || result.ready;
  assign pop        = head.valid && back_ready;
  assign apply      = pop && !finished;
  assign sel        = SW'(head.cmd.stream);

  // Refill or end the addressed head.
  always_comb begin
    key_next   = head_key;
    valid_next = head_valid;
    ended_next = head_ended;
    if (apply) begin
      if (head.cmd.stream_end) begin
        ended_next[sel] = 1'b1;
        valid_next[sel] = 1'b0;
      end else if (!head_ended[sel]) begin
        key_next[sel]   = head.cmd.key;
        valid_next[sel] = 1'b1;
      end
    end
  end

  // Minimum tree; left child holds lower indices, so it wins ties.
  always_comb begin
    for (int n = 0; n < P; n++) begin
      node_v[n] = 1'b0;
      node_k[n] = '0;
      node_i[n] = '0;
    end
    for (int l = 0; l < P; l++) begin
      node_v[P+l] = (l < STREAMS) ? valid_next[l] : 1'b0;
      node_k[P+l] = (l < STREAMS) ? key_next[l] : '0;
      node_i[P+l] = SW'(l);
    end
    for (int n = P - 1; n >= 1; n--) begin
      if (node_v[2*n] && (!node_v[2*n+1] || node_k[2*n] <= node_k[2*n+1])) begin
        node_v[n] = node_v[2*n];
        node_k[n] = node_k[2*n];
        node_i[n] = node_i[2*n];
      end else begin
        node_v[n] = node_v[2*n+1];
        node_k[n] = node_k[2*n+1];
        node_i[n] = node_i[2*n+1];
      end
    end
  end

  assign all_end     = &ended_next;
  assign heads_ready = &(valid_next | ended_next);
  assign emit        = apply && (all_end || (heads_ready && node_v[1]));

  // drop the winning head so its stream must refill
  always_comb begin
    win_clear = '0;
    if (!all_end && heads_ready && node_v[1]) begin
      win_clear[node_i[1]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      head_key <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      head_ended <= '0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (apply) begin
        head_ended <= ended_next;
        head_valid <= valid_next & ~win_clear;
        if (all_end) begin
          finished <= 1'b1;
        end
      end
      if (pop) begin
        out_valid <= emit;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_done   <= all_end;
      out_stream <= all_end ? '0 : STREAM_W'(node_i[1]);
      out_key    <= all_end ? '0 : node_k[1];
    end
  end

  assign result.valid         = out_valid;
  assign result.winner_stream = out_stream;
  assign result.winner_key    = out_key;
  assign result.all_done      = out_done;

endmodule

>>> rtl/core/kway_merge_selector_top.sv
// kway_merge_selector_top: k-way merge selector, front/queue/back.
// Depends on kms_pkg, kms_in_if, kms_out_if, kms_front, kms_queue, kms_back.
//
//   channel  dir  fields                                   beat when
//   refill   in   stream[2:0] key[30:0] stream_end         valid && ready
//   result   out  winner_stream[2:0] winner_key[30:0]      valid && ready
//                 all_done
//
// One refill beat per cycle while the queue is not full; the back end applies
// one queued refill per cycle while the result is not stalled, and selects
// the minimum over all heads in that cycle. A refill beat passes through the
// queue and then the output register before result valid rises.
// Reset is synchronous and clears all heads, flags and the queue.
// A stalled result holds the back end; the queue absorbs up to four refills.
module kway_merge_selector_top #(
  parameter int STREAMS = kms_pkg::STREAMS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kms_in_if.sink    refill,
  kms_out_if.source result
);
  import kms_pkg::*;

  push_t   push;
  head_t   head;
  q_stat_t q_stat;
  logic    pop;

  kms_front #(.STREAMS(STREAMS)) u_front (
    .rst    (rst),
    .refill (refill),
    .q_stat (q_stat),
    .push   (push)
  );

  kms_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (q_stat)
  );

  kms_back #(.STREAMS(STREAMS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

  a_q_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (!q_stat.full && refill.valid && refill.ready))
    else $error("push into full queue or without a refill beat");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.all_done) |-> (result.winner_key == '0 &&
                                           result.winner_stream == '0))
    else $error("done result carries non-zero fields");

  a_pop_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule
